// ===== design/pecq_pkg.sv =====
// Shared types, constants and priority function for the command queue.
package pecq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [1:0] REG_ESTOP_TYPE = 2'd0;
    localparam logic [1:0] REG_CRITICAL   = 2'd1;
    localparam logic [1:0] REG_NORMAL     = 2'd2;

    localparam logic [7:0] ESTOP_TYPE_RESET = 8'd0;
    localparam logic [7:0] CRITICAL_RESET   = 8'd3;
    localparam logic [7:0] NORMAL_RESET     = 8'd1;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic [7:0]  robot_number;
        logic [7:0]  command_type;
        logic [31:0] vel_x_bits;
        logic [31:0] vel_y_bits;
        logic [31:0] turn_rate_bits;
        logic [31:0] sequence_number;
        logic [7:0]  priority_level;
        logic [7:0]  flag_bits;
    } entry_t;

    typedef struct packed {
        logic [7:0] estop_type;
        logic [7:0] critical;
        logic [7:0] normal;
    } level_cfg_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } state_t;

    function automatic logic [7:0] eff_prio(entry_t e, level_cfg_t c);
        logic [7:0] p;
        if (e.priority_level != 8'd0)
            p = e.priority_level;
        else if (e.command_type == c.estop_type)
            p = c.critical;
        else
            p = c.normal;
        return p;
    endfunction

endpackage

// ===== design/pecq_cell.sv =====
// One queue cell: holds an entry, takes its neighbor's entry or a new one.
module pecq_cell (
    input  logic                   clk,
    input  pecq_pkg::cell_ctrl_t   ctrl,
    input  pecq_pkg::entry_t       neighbor_entry,
    input  pecq_pkg::entry_t       new_entry,
    input  pecq_pkg::level_cfg_t   level_cfg,
    output pecq_pkg::entry_t       entry,
    output logic [7:0]             prio
);

    pecq_pkg::entry_t entry_reg;
    pecq_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
            entry_next = new_entry;
        else if (ctrl.shift)
            entry_next = neighbor_entry;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign prio  = pecq_pkg::eff_prio(entry_reg, level_cfg);

endmodule

// ===== design/priority_evicting_command_queue_unit.sv =====
// Top level: bounded priority command queue with lowest-priority eviction.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  kind, entry fields
//   out       source     out_valid / out_stall accepted, evicted, entry, drop_total
//   cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Pop and non-full push: the request is captured, then the cells are updated and the result registered.
// Push to a full queue: the request is captured, then the oldest lowest-priority
// cell is found by a scan that visits one cell per cycle, then the result is registered.
// Reset clears control, counters and config; cell contents are not reset.
// A finished result waits in the output register while out_stall is high.
module priority_evicting_command_queue_unit #(
    parameter int QUEUE_DEPTH = pecq_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  robot_number,
    input  logic [7:0]  command_type,
    input  logic [31:0] vel_x_bits,
    input  logic [31:0] vel_y_bits,
    input  logic [31:0] turn_rate_bits,
    input  logic [31:0] sequence_number,
    input  logic [7:0]  priority_level,
    input  logic [7:0]  flag_bits,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic        evicted,
    output logic        entry_valid,
    output logic [7:0]  out_robot_number,
    output logic [7:0]  out_command_type,
    output logic [31:0] out_vel_x_bits,
    output logic [31:0] out_vel_y_bits,
    output logic [31:0] out_turn_rate_bits,
    output logic [31:0] out_sequence_number,
    output logic [7:0]  out_priority_level,
    output logic [7:0]  out_flag_bits,
    output logic [31:0] drop_total,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    pecq_pkg::state_t     state_reg, state_next;
    pecq_pkg::level_cfg_t cfg_reg, cfg_next;
    pecq_pkg::entry_t     req_reg, req_next;
    logic                 req_kind_reg, req_kind_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [31:0]          drop_reg, drop_next;
    logic [IDX_W-1:0]     scan_pos_reg, scan_pos_next;
    logic [IDX_W-1:0]     min_idx_reg, min_idx_next;
    logic [7:0]           min_prio_reg, min_prio_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 accepted_reg, accepted_next;
    logic                 evicted_reg, evicted_next;
    logic                 entry_valid_reg, entry_valid_next;
    pecq_pkg::entry_t     out_entry_reg, out_entry_next;
    logic [31:0]          out_drop_reg, out_drop_next;

    pecq_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    logic [7:0]           cell_prio  [QUEUE_DEPTH];
    pecq_pkg::cell_ctrl_t cell_ctrl  [QUEUE_DEPTH];

    logic                 out_free;
    logic                 full;
    logic [7:0]           new_prio;

    assign out_free = !out_valid_reg || !out_stall;
    assign full     = (count_reg == FULL_CNT);
    assign new_prio = pecq_pkg::eff_prio(req_reg, cfg_reg);

    // cell row, position 0 is the oldest entry
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        pecq_pkg::entry_t neighbor;
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign neighbor = cell_entry[i];
        end
        else
        begin : g_mid
            assign neighbor = cell_entry[i+1];
        end

        pecq_cell u_cell (
            .clk            (clk),
            .ctrl           (cell_ctrl[i]),
            .neighbor_entry (neighbor),
            .new_entry      (req_reg),
            .level_cfg      (cfg_reg),
            .entry          (cell_entry[i]),
            .prio           (cell_prio[i])
        );
    end

    // config registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pecq_pkg::REG_ESTOP_TYPE: cfg_next.estop_type = cfg_data;
                pecq_pkg::REG_CRITICAL:   cfg_next.critical   = cfg_data;
                pecq_pkg::REG_NORMAL:     cfg_next.normal     = cfg_data;
                default:                  cfg_next            = cfg_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pecq_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = pecq_pkg::ST_EXEC;
            end
            pecq_pkg::ST_EXEC:
            begin
                if (req_kind_reg == pecq_pkg::KIND_PUSH && full)
                    state_next = pecq_pkg::ST_SCAN;
                else if (out_free)
                    state_next = pecq_pkg::ST_IDLE;
            end
            pecq_pkg::ST_SCAN:
            begin
                if (scan_pos_reg == LAST_IDX)
                    state_next = pecq_pkg::ST_FINISH;
            end
            pecq_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = pecq_pkg::ST_IDLE;
            end
            default:
                state_next = pecq_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_stall         = (state_reg != pecq_pkg::ST_IDLE);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            cell_ctrl[i] = '0;
        req_next         = req_reg;
        req_kind_next    = req_kind_reg;
        count_next       = count_reg;
        drop_next        = drop_reg;
        scan_pos_next    = scan_pos_reg;
        min_idx_next     = min_idx_reg;
        min_prio_next    = min_prio_reg;
        out_valid_next   = out_valid_reg && out_stall;
        accepted_next    = accepted_reg;
        evicted_next     = evicted_reg;
        entry_valid_next = entry_valid_reg;
        out_entry_next   = out_entry_reg;
        out_drop_next    = out_drop_reg;

        case (state_reg)
            pecq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_kind_next                = kind;
                    req_next.robot_number        = robot_number;
                    req_next.command_type        = command_type;
                    req_next.vel_x_bits          = vel_x_bits;
                    req_next.vel_y_bits          = vel_y_bits;
                    req_next.turn_rate_bits      = turn_rate_bits;
                    req_next.sequence_number     = sequence_number;
                    req_next.priority_level      = priority_level;
                    req_next.flag_bits           = flag_bits;
                end
            end
            pecq_pkg::ST_EXEC:
            begin
                if (req_kind_reg == pecq_pkg::KIND_PUSH && full)
                begin
                    scan_pos_next = IDX_W'(1);
                    min_idx_next  = '0;
                    min_prio_next = cell_prio[0];
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    evicted_next     = 1'b0;
                    out_entry_next   = '0;
                    entry_valid_next = 1'b0;
                    accepted_next    = 1'b0;
                    if (req_kind_reg == pecq_pkg::KIND_POP)
                    begin
                        if (count_reg != '0)
                        begin
                            accepted_next    = 1'b1;
                            entry_valid_next = 1'b1;
                            out_entry_next   = cell_entry[0];
                            count_next       = count_reg - CNT_W'(1);
                            for (int i = 0; i < QUEUE_DEPTH; i++)
                                cell_ctrl[i].shift = 1'b1;
                        end
                    end
                    else
                    begin
                        accepted_next = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        for (int i = 0; i < QUEUE_DEPTH; i++)
                            cell_ctrl[i].load = (CNT_W'(i) == count_reg);
                    end
                end
            end
            pecq_pkg::ST_SCAN:
            begin
                if (cell_prio[scan_pos_reg] < min_prio_reg)
                begin
                    min_prio_next = cell_prio[scan_pos_reg];
                    min_idx_next  = scan_pos_reg;
                end
                scan_pos_next = scan_pos_reg + IDX_W'(1);
            end
            pecq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    entry_valid_next = 1'b0;
                    out_entry_next   = '0;
                    accepted_next    = 1'b0;
                    evicted_next     = 1'b0;
                    if (new_prio >= min_prio_reg)
                    begin
                        accepted_next = 1'b1;
                        evicted_next  = 1'b1;
                        drop_next     = drop_reg + 32'd1;
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                            cell_ctrl[i].shift = (IDX_W'(i) >= min_idx_reg);
                        cell_ctrl[QUEUE_DEPTH-1].load = 1'b1;
                    end
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase

        if (out_valid_next && !(out_valid_reg && out_stall))
            out_drop_next = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= pecq_pkg::ST_IDLE;
            cfg_reg.estop_type <= pecq_pkg::ESTOP_TYPE_RESET;
            cfg_reg.critical   <= pecq_pkg::CRITICAL_RESET;
            cfg_reg.normal     <= pecq_pkg::NORMAL_RESET;
            count_reg          <= '0;
            drop_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        req_kind_reg    <= req_kind_next;
        scan_pos_reg    <= scan_pos_next;
        min_idx_reg     <= min_idx_next;
        min_prio_reg    <= min_prio_next;
        accepted_reg    <= accepted_next;
        evicted_reg     <= evicted_next;
        entry_valid_reg <= entry_valid_next;
        out_entry_reg   <= out_entry_next;
        out_drop_reg    <= out_drop_next;
    end

    assign out_valid           = out_valid_reg;
    assign accepted            = accepted_reg;
    assign evicted             = evicted_reg;
    assign entry_valid         = entry_valid_reg;
    assign out_robot_number    = out_entry_reg.robot_number;
    assign out_command_type    = out_entry_reg.command_type;
    assign out_vel_x_bits      = out_entry_reg.vel_x_bits;
    assign out_vel_y_bits      = out_entry_reg.vel_y_bits;
    assign out_turn_rate_bits  = out_entry_reg.turn_rate_bits;
    assign out_sequence_number = out_entry_reg.sequence_number;
    assign out_priority_level  = out_entry_reg.priority_level;
    assign out_flag_bits       = out_entry_reg.flag_bits;
    assign drop_total          = out_drop_reg;

endmodule
